FILE: sv/magic_sync_frame_checksum_checker_macros.svh
// ---------------------------------------------------------------------------
// magic sync frame checksum checker assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is set
// ---------------------------------------------------------------------------
`ifndef MAGIC_SYNC_FRAME_CHECKSUM_CHECKER_MACROS_SVH
`define MAGIC_SYNC_FRAME_CHECKSUM_CHECKER_MACROS_SVH

`ifndef ASSERT_OFF

// checked only while out of reset
`define MSFCC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("msfcc assertion failed");

// checked on every edge, reset included
`define MSFCC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("msfcc assertion failed");

`else

`define MSFCC_ASSERT(label, clk, rst_n, prop)
`define MSFCC_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

FILE: sv/msfcc_pkg.sv
// ---------------------------------------------------------------------------
// msfcc_pkg
// shared types, constants and checksum helpers of the sync frame checker
// ---------------------------------------------------------------------------
`default_nettype none

package msfcc_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 5;
    localparam int unsigned CFG_IDX_W = 1;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_WORD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED      = 1'd1;

    localparam logic [WORD_W-1:0] RESET_SYNC_WORD = 32'h3143_5641;
    localparam logic [WORD_W-1:0] RESET_SEED      = 32'hA5A5_1234;

    // frame byte positions
    localparam logic [COUNT_W-1:0] HUNT_FULL   = 5'd3;
    localparam logic [COUNT_W-1:0] SYNC_BYTES  = 5'd4;
    localparam logic [COUNT_W-1:0] VALID_BYTE  = 5'd16;
    localparam logic [COUNT_W-1:0] SUM_BYTES   = 5'd20;
    localparam logic [COUNT_W-1:0] LAST_BYTE   = 5'd23;

    typedef enum logic {
        PH_HUNT,
        PH_FRAME
    } t_phase;

    typedef struct packed {
        logic [WORD_W-1:0] sequence_res;
        logic [WORD_W-1:0] x_velocity_bits;
        logic [WORD_W-1:0] y_velocity_bits;
        logic [BYTE_W-1:0] valid_flag;
        logic [WORD_W-1:0] received_sum;
        logic [WORD_W-1:0] computed_sum;
        logic              sum_ok;
    } t_result;

    function automatic logic [WORD_W-1:0] sum_update(
        input logic [WORD_W-1:0] c,
        input logic [BYTE_W-1:0] b
    );
        return (c << 5) ^ (c >> 2) ^ {{(WORD_W-BYTE_W){1'b0}}, b};
    endfunction

    function automatic logic [WORD_W-1:0] shift_in(
        input logic [WORD_W-1:0] acc,
        input logic [BYTE_W-1:0] b
    );
        return {b, acc[WORD_W-1:BYTE_W]};
    endfunction

    // checksum over the four sync bytes, low byte first
    function automatic logic [WORD_W-1:0] sync_sum(
        input logic [WORD_W-1:0] seed,
        input logic [WORD_W-1:0] word
    );
        logic [WORD_W-1:0] c;
        c = seed;
        for (int k = 0; k < 4; k++) begin
            c = sum_update(c, word[k*BYTE_W +: BYTE_W]);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: sv/msfcc_frame_parser.sv
// ---------------------------------------------------------------------------
// msfcc_frame_parser
// sync hunt, frame field collection and running checksum, one byte a cycle while i_go is high
// ---------------------------------------------------------------------------
`default_nettype none

`include "magic_sync_frame_checksum_checker_macros.svh"

module msfcc_frame_parser (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_go,
    input  wire logic [7:0]                i_byte,
    input  wire logic [31:0]               i_sync_word,
    input  wire logic [31:0]               i_seed,
    output logic                           o_emit,
    output msfcc_pkg::t_result             o_result
);
    import msfcc_pkg::*;

    t_phase              r_phase, n_phase;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic [23:0]         r_window, n_window;
    logic [WORD_W-1:0]   r_sum, n_sum;
    logic [WORD_W-1:0]   r_seq, n_seq;
    logic [WORD_W-1:0]   r_vx, n_vx;
    logic [WORD_W-1:0]   r_vy, n_vy;
    logic [BYTE_W-1:0]   r_valid_b, n_valid_b;
    logic [WORD_W-1:0]   r_trailer, n_trailer;

    logic [WORD_W-1:0]   w_word;
    logic                w_match;
    logic                w_last;
    logic [WORD_W-1:0]   w_trailer;

    assign w_word    = {i_byte, r_window};
    assign w_match   = (r_count >= HUNT_FULL) && (w_word == i_sync_word);
    assign w_last    = (r_count == LAST_BYTE);
    assign w_trailer = shift_in(r_trailer, i_byte);

    // the held byte closes a frame, whether or not it moves this cycle
    assign o_emit    = (r_phase == PH_FRAME) && w_last;

    // next state
    always_comb begin
        n_phase = r_phase;
        if (i_go) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (w_match) n_phase = PH_FRAME;
                end
                PH_FRAME: begin
                    if (w_last) n_phase = PH_HUNT;
                end
                default: n_phase = PH_HUNT;
            endcase
        end
    end

    // datapath and result
    always_comb begin
        n_count   = r_count;
        n_window  = r_window;
        n_sum     = r_sum;
        n_seq     = r_seq;
        n_vx      = r_vx;
        n_vy      = r_vy;
        n_valid_b = r_valid_b;
        n_trailer = r_trailer;

        o_result.sequence_res    = r_seq;
        o_result.x_velocity_bits = r_vx;
        o_result.y_velocity_bits = r_vy;
        o_result.valid_flag      = r_valid_b;
        o_result.received_sum    = w_trailer;
        o_result.computed_sum    = r_sum;
        o_result.sum_ok          = (w_trailer == r_sum);

        if (i_go) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (w_match) begin
                        n_sum    = sync_sum(i_seed, w_word);
                        n_count  = SYNC_BYTES;
                        n_window = '0;
                    end else begin
                        n_window = w_word[WORD_W-1:BYTE_W];
                        if (r_count < HUNT_FULL) n_count = r_count + 5'd1;
                        else                     n_count = HUNT_FULL;
                    end
                end
                PH_FRAME: begin
                    if (r_count < SUM_BYTES) n_sum = sum_update(r_sum, i_byte);
                    priority if (r_count[4:2] == 3'd1) n_seq = shift_in(r_seq, i_byte);
                    else if (r_count[4:2] == 3'd2)     n_vx  = shift_in(r_vx, i_byte);
                    else if (r_count[4:2] == 3'd3)     n_vy  = shift_in(r_vy, i_byte);
                    else if (r_count == VALID_BYTE)    n_valid_b = i_byte;
                    else if (r_count >= SUM_BYTES)     n_trailer = w_trailer;
                    else begin
                    end
                    if (w_last) begin
                        n_count  = '0;
                        n_window = '0;
                    end else begin
                        n_count = r_count + 5'd1;
                    end
                end
                default: begin
                    n_count = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_count  <= '0;
            r_window <= '0;
            r_sum    <= RESET_SEED;
        end else begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_window <= n_window;
            r_sum    <= n_sum;
        end
    end

    // field accumulators, always rewritten before a result uses them
    always_ff @(posedge i_clk) begin
        r_seq     <= n_seq;
        r_vx      <= n_vx;
        r_vy      <= n_vy;
        r_valid_b <= n_valid_b;
        r_trailer <= n_trailer;
    end

    `MSFCC_ASSERT(a_frame_count_range, i_clk, i_rst_n,
        (r_phase == PH_FRAME) |-> (r_count >= SYNC_BYTES) && (r_count <= LAST_BYTE))
    `MSFCC_ASSERT(a_hunt_count_range, i_clk, i_rst_n,
        (r_phase == PH_HUNT) |-> (r_count <= HUNT_FULL))
    `MSFCC_ASSERT(a_emit_ends_frame, i_clk, i_rst_n,
        (o_emit && i_go) |=> (r_phase == PH_HUNT) && (r_count == 5'd0))

endmodule

`default_nettype wire

FILE: sv/msfcc_result_reg.sv
// ---------------------------------------------------------------------------
// msfcc_result_reg
// output register holding one finished frame result until it is taken
// ---------------------------------------------------------------------------
`default_nettype none

`include "magic_sync_frame_checksum_checker_macros.svh"

module msfcc_result_reg (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_load,
    input  wire msfcc_pkg::t_result   i_data,
    input  wire logic                 i_ready,
    output logic                      o_free,
    output logic                      o_valid,
    output msfcc_pkg::t_result        o_data
);
    import msfcc_pkg::*;

    logic    r_valid, n_valid;
    t_result r_data;

    // slot can take a new result this cycle when empty or being drained
    assign o_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load)       n_valid = 1'b1;
        else if (i_ready) n_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) r_data <= i_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

    `MSFCC_ASSERT(a_no_overwrite, i_clk, i_rst_n, i_load |-> (!r_valid || i_ready))

endmodule

`default_nettype wire

FILE: sv/magic_sync_frame_checksum_checker.sv
// path: input register, parser, then the result register that offers each result
// throughput: one byte per cycle; the input register, the parser and the
// result register each move a beat a cycle unless a held result blocks a frame end
// reset: synchronous active low; registers return to their reset values,
// the block hunts with an empty window and holds no result
// ---------------------------------------------------------------------------
// magic_sync_frame_checksum_checker
// sync word hunt, 24-byte frame capture and shift-xor checksum check
// ---------------------------------------------------------------------------
`default_nettype none

module magic_sync_frame_checksum_checker (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire logic [7:0]   i_rx_byte,
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic [31:0]       o_sequence_res,
    output logic [31:0]       o_x_velocity_bits,
    output logic [31:0]       o_y_velocity_bits,
    output logic [7:0]        o_valid_flag,
    output logic [31:0]       o_received_sum,
    output logic [31:0]       o_computed_sum,
    output logic              o_sum_ok,
    input  wire logic         i_cfg_we,
    input  wire logic [msfcc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]  i_cfg_wdata
);
    import msfcc_pkg::*;

    logic [WORD_W-1:0] r_sync_word;
    logic [WORD_W-1:0] r_seed;
    logic              r_in_valid, n_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    logic    w_emit;
    logic    w_free;
    logic    w_advance;
    t_result w_result;
    t_result w_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_word <= RESET_SYNC_WORD;
            r_seed      <= RESET_SEED;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SYNC_WORD: r_sync_word <= i_cfg_wdata;
                CFG_SEED:      r_seed      <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // the held byte moves on unless it finishes a frame while the result slot is full
    assign w_advance = r_in_valid && (!w_emit || w_free);
    assign o_ready   = !r_in_valid || w_advance;

    always_comb begin
        n_in_valid = r_in_valid;
        if (i_valid && o_ready) n_in_valid = 1'b1;
        else if (w_advance)     n_in_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) r_in_byte <= i_rx_byte;
    end

    msfcc_frame_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (w_advance),
        .i_byte      (r_in_byte),
        .i_sync_word (r_sync_word),
        .i_seed      (r_seed),
        .o_emit      (w_emit),
        .o_result    (w_result)
    );

    msfcc_result_reg u_result (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_advance && w_emit),
        .i_data  (w_result),
        .i_ready (i_ready),
        .o_free  (w_free),
        .o_valid (o_valid),
        .o_data  (w_out)
    );

    assign o_sequence_res    = w_out.sequence_res;
    assign o_x_velocity_bits = w_out.x_velocity_bits;
    assign o_y_velocity_bits = w_out.y_velocity_bits;
    assign o_valid_flag      = w_out.valid_flag;
    assign o_received_sum    = w_out.received_sum;
    assign o_computed_sum    = w_out.computed_sum;
    assign o_sum_ok          = w_out.sum_ok;

endmodule

`default_nettype wire

FILE: bench/tb_magic_sync_frame_checksum_checker.sv
// ---------------------------------------------------------------------------
// tb_magic_sync_frame_checksum_checker
// self-checking bench: a byte stream of framed, broken and noise sequences is
// driven through valid/ready with random gaps and back-pressure; every frame
// result is compared field by field with a local model of the sync hunt,
// field capture and shift-xor checksum, over several register settings
// ---------------------------------------------------------------------------
module tb_magic_sync_frame_checksum_checker;
    timeunit 1ns;
    timeprecision 1ps;

    import msfcc_pkg::*;

    localparam int GAP_PCT      = 24;
    localparam int HOLD_CYCLES  = 600;
    localparam int HOLD_AT_BYTE = 320;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 8;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_ready;
    logic [7:0]           i_rx_byte   = '0;
    logic                 o_valid;
    logic                 i_ready     = 1'b0;
    logic [31:0]          o_sequence_res;
    logic [31:0]          o_x_velocity_bits;
    logic [31:0]          o_y_velocity_bits;
    logic [7:0]           o_valid_flag;
    logic [31:0]          o_received_sum;
    logic [31:0]          o_computed_sum;
    logic                 o_sum_ok;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_SYNC_WORD;
    logic [31:0]          i_cfg_wdata = '0;

    magic_sync_frame_checksum_checker uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_rx_byte         (i_rx_byte),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_sequence_res    (o_sequence_res),
        .o_x_velocity_bits (o_x_velocity_bits),
        .o_y_velocity_bits (o_y_velocity_bits),
        .o_valid_flag      (o_valid_flag),
        .o_received_sum    (o_received_sum),
        .o_computed_sum    (o_computed_sum),
        .o_sum_ok          (o_sum_ok),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    // register copies and decoder state of the local model
    logic [31:0] m_sync;
    logic [31:0] m_seed;
    t_phase      m_phase;
    logic [23:0] m_window;
    logic [4:0]  m_count;
    logic [31:0] m_sum;
    logic [31:0] m_seq;
    logic [31:0] m_vx;
    logic [31:0] m_vy;
    logic [7:0]  m_flag;
    logic [31:0] m_trailer;

    logic [7:0] tx_bytes [$];
    t_result    due_frames [$];
    t_result    head;

    logic byte_taken     = 1'b0;
    logic no_gaps        = 1'b0;
    logic long_hold_done = 1'b0;
    int   hold_left      = 0;
    int   quiet_cycles   = 0;
    int   bytes_in       = 0;
    int   bytes_queued   = 0;
    int   frames_queued  = 0;
    int   frames_seen    = 0;
    int   good_frames    = 0;
    int   bad_frames     = 0;
    int   settings       = 1;
    int   errors         = 0;

    function automatic logic [31:0] mix_byte(input logic [31:0] c, input logic [7:0] b);
        return (c << 5) ^ (c >> 2) ^ {24'd0, b};
    endfunction

    // advance the model by one accepted byte, queueing a result at frame end
    task automatic absorb_byte(input logic [7:0] b);
        logic [31:0] word;
        t_result     r;
        if (m_phase == PH_HUNT) begin
            word = {b, m_window};
            if (m_count >= HUNT_FULL && word == m_sync) begin
                m_sum = m_seed;
                for (int k = 0; k < 4; k++) m_sum = mix_byte(m_sum, word[8*k +: 8]);
                m_phase  = PH_FRAME;
                m_count  = SYNC_BYTES;
                m_window = '0;
            end else begin
                m_window = word[31:8];
                if (m_count < HUNT_FULL) m_count = m_count + 1'b1;
            end
        end else begin
            if (m_count < SUM_BYTES) m_sum = mix_byte(m_sum, b);
            if (m_count >= 5'd4 && m_count <= 5'd7) begin
                m_seq = {b, m_seq[31:8]};
            end else if (m_count >= 5'd8 && m_count <= 5'd11) begin
                m_vx = {b, m_vx[31:8]};
            end else if (m_count >= 5'd12 && m_count <= 5'd15) begin
                m_vy = {b, m_vy[31:8]};
            end else if (m_count == VALID_BYTE) begin
                m_flag = b;
            end else if (m_count >= SUM_BYTES) begin
                m_trailer = {b, m_trailer[31:8]};
            end
            if (m_count >= LAST_BYTE) begin
                r.sequence_res    = m_seq;
                r.x_velocity_bits = m_vx;
                r.y_velocity_bits = m_vy;
                r.valid_flag      = m_flag;
                r.received_sum    = m_trailer;
                r.computed_sum    = m_sum;
                r.sum_ok          = (m_trailer == m_sum);
                due_frames.push_back(r);
                m_phase  = PH_HUNT;
                m_count  = '0;
                m_window = '0;
            end else begin
                m_count = m_count + 1'b1;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want, got);
        if (want !== got) begin
            errors++;
            if (errors <= 10)
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    task automatic queue_byte(input logic [7:0] b);
        tx_bytes.push_back(b);
        bytes_queued++;
    endtask

    task automatic queue_noise(input int n);
        for (int k = 0; k < n; k++) queue_byte(8'($urandom));
    endtask

    // one frame under the current settings, optionally cut short
    task automatic queue_frame(input logic [31:0] seq, vx, vy, input logic [7:0] flag,
                               input bit corrupt, input int keep);
        logic [7:0]  fb [24];
        logic [31:0] sum;
        logic [31:0] trailer;
        for (int k = 0; k < 4; k++) begin
            fb[k]      = m_sync[8*k +: 8];
            fb[4 + k]  = seq[8*k +: 8];
            fb[8 + k]  = vx[8*k +: 8];
            fb[12 + k] = vy[8*k +: 8];
        end
        fb[16] = flag;
        for (int k = 17; k < 20; k++) fb[k] = 8'($urandom);
        sum = m_seed;
        for (int k = 0; k < 20; k++) sum = mix_byte(sum, fb[k]);
        trailer = sum;
        if (corrupt)
            trailer = sum ^ ($urandom_range(1) ? 32'hFFFF_FFFF : (32'd1 << $urandom_range(31)));
        for (int k = 0; k < 4; k++) fb[20 + k] = trailer[8*k +: 8];
        for (int k = 0; k < keep; k++) queue_byte(fb[k]);
    endtask

    task automatic settle();
        do @(posedge i_clk);
        while (tx_bytes.size() != 0 || i_valid || due_frames.size() != 0);
        // a byte that ends no frame may still be in flight
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [31:0] sync, seed);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SYNC_WORD;
        i_cfg_wdata <= sync;
        m_sync = sync;
        @(negedge i_clk);
        i_cfg_index <= CFG_SEED;
        i_cfg_wdata <= seed;
        m_seed = seed;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings++;
    endtask

    // sender: payload changes only once the current beat has gone
    always @(negedge i_clk) begin
        if (!i_valid || byte_taken) begin
            if (tx_bytes.size() != 0 && (no_gaps || $urandom_range(99) >= GAP_PCT)) begin
                i_valid   <= 1'b1;
                i_rx_byte <= tx_bytes.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus one long hold-off to back the block up
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!long_hold_done && bytes_in >= HOLD_AT_BYTE) begin
            i_ready        <= 1'b0;
            hold_left      <= HOLD_CYCLES;
            long_hold_done <= 1'b1;
        end else begin
            i_ready <= no_gaps || ($urandom_range(99) >= GAP_PCT);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_taken <= 1'b0;
        end else begin
            byte_taken <= i_valid && o_ready;
            if (o_valid && i_ready) begin
                frames_seen++;
                if (due_frames.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: result beat with nothing due, sequence %h",
                                 $time, o_sequence_res);
                end else begin
                    head = due_frames.pop_front();
                    check_field("sequence_res", head.sequence_res, o_sequence_res);
                    check_field("x_velocity_bits", head.x_velocity_bits, o_x_velocity_bits);
                    check_field("y_velocity_bits", head.y_velocity_bits, o_y_velocity_bits);
                    check_field("valid_flag", {24'd0, head.valid_flag}, {24'd0, o_valid_flag});
                    check_field("received_sum", head.received_sum, o_received_sum);
                    check_field("computed_sum", head.computed_sum, o_computed_sum);
                    check_field("sum_ok", {31'd0, head.sum_ok}, {31'd0, o_sum_ok});
                    if (head.sum_ok) good_frames++;
                    else bad_frames++;
                end
            end
            if (i_valid && o_ready) begin
                absorb_byte(i_rx_byte);
                bytes_in++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no beat in either direction for %0d cycles", STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int r;
        int n;
        int phase_no;
        int phase_start;
        int random_start;
        logic [31:0] pick;

        m_sync    = RESET_SYNC_WORD;
        m_seed    = RESET_SEED;
        m_phase   = PH_HUNT;
        m_window  = '0;
        m_count   = '0;
        m_sum     = RESET_SEED;
        m_seq     = '0;
        m_vx      = '0;
        m_vy      = '0;
        m_flag    = '0;
        m_trailer = '0;
        phase_no  = 0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values: sync preceded by its own first bytes, so the window slides
        for (int k = 0; k < 3; k++) queue_byte(m_sync[8*k +: 8]);
        queue_frame('0, '0, '0, 8'h00, 1'b0, 24);
        queue_frame('1, '1, '1, 8'hFF, 1'b0, 24);
        // sync word sitting inside a frame body is just data
        queue_frame(m_sync, m_sync, $urandom, 8'h5A, 1'b1, 24);
        queue_frame('0, '0, '0, 8'h00, 1'b1, 24);
        settle();

        // zero sync word: an unfilled window must not match
        set_config('0, '0);
        queue_frame('0, '0, '0, 8'h00, 1'b0, 24);
        queue_frame($urandom, $urandom, $urandom, 8'($urandom), 1'b0, 24);
        settle();

        set_config('1, '1);
        queue_frame('1, '1, '1, 8'hFF, 1'b0, 24);
        queue_frame('0, '0, '0, 8'h00, 1'b1, 24);
        // leave a frame open across the next register writes
        queue_frame($urandom, $urandom, $urandom, 8'($urandom), 1'b0, 12);
        settle();

        random_start = bytes_queued;
        while (bytes_queued - random_start < 1000 || frames_queued < 32) begin
            phase_no++;
            no_gaps = (phase_no == 3);
            case ($urandom_range(2))
                0:       pick = {4{8'($urandom)}};
                1:       pick = {2{16'($urandom)}};
                default: pick = $urandom;
            endcase
            set_config(pick, $urandom);
            phase_start = bytes_queued;
            while (bytes_queued - phase_start < 260) begin
                r = $urandom_range(99);
                if (r < 70) begin
                    queue_noise($urandom_range(3));
                    queue_frame($urandom, $urandom, $urandom, 8'($urandom),
                                $urandom_range(99) < 20, 24);
                    frames_queued++;
                end else if (r < 85) begin
                    queue_frame($urandom, $urandom, $urandom, 8'($urandom), 1'b0,
                                $urandom_range(23, 1));
                end else begin
                    if ($urandom_range(1)) begin
                        n = $urandom_range(3, 1);
                        for (int k = 0; k < n; k++) queue_byte(m_sync[8*k +: 8]);
                    end
                    queue_noise($urandom_range(8, 1));
                end
            end
            settle();
        end
        no_gaps = 1'b0;

        if (due_frames.size() != 0) begin
            errors += due_frames.size();
            $display("%0d frame results never arrived", due_frames.size());
        end
        $display("%0d bytes sent over %0d register settings, %0d random phases",
                 bytes_in, settings, phase_no);
        $display("%0d frame results checked: %0d with matching checksum, %0d without",
                 frames_seen, good_frames, bad_frames);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", errors);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/msfcc_pkg.sv
sv/msfcc_frame_parser.sv
sv/msfcc_result_reg.sv
sv/magic_sync_frame_checksum_checker.sv
bench/tb_magic_sync_frame_checksum_checker.sv
